@@ rtl/mffr_pkg.sv @@
// ----------------------------------------------------------------------------
// Multi-format frame receiver package
// Shared constants, types and helper functions for the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package mffr_pkg;

  // Frame store geometry.
  localparam int BUF_LEN = 64;
  localparam int IDX_W   = $clog2(BUF_LEN);
  localparam int CNT_W   = IDX_W + 1;

  // Command queue between the front and the back.
  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = CQ_PTR_W + 1;

  // Byte values that the receiver recognizes.
  localparam logic [7:0] BYTE_ZIGBEE = 8'h55;
  localparam logic [7:0] BYTE_HDR0   = 8'hC1;
  localparam logic [7:0] BYTE_HDR1   = 8'hC2;
  localparam logic [7:0] BYTE_HDR2   = 8'hC3;
  localparam logic [7:0] BYTE_HDR3   = 8'hC4;
  localparam logic [7:0] BYTE_CR     = 8'h0D;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] BYTE_B      = 8'h42;
  localparam logic [7:0] BYTE_U      = 8'h55;
  localparam logic [7:0] BYTE_S      = 8'h53;
  localparam logic [7:0] BYTE_Y      = 8'h59;

  // Word length that raises the enter-mode event, and the custom header length.
  localparam logic [CNT_W-1:0] WORD_LEN = CNT_W'(4);
  localparam logic [CNT_W-1:0] HDR_LEN  = CNT_W'(4);
  localparam logic [CNT_W-1:0] BUF_FULL = CNT_W'(BUF_LEN);

  // Frame hunting mode.
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ZIGBEE = 2'd1,
    MODE_CUSTOM = 2'd2,
    MODE_WORD   = 2'd3
  } mode_t;

  // Kind of a result item.
  typedef enum logic [1:0] {
    EVT_ZIGBEE = 2'd0,
    EVT_CUSTOM = 2'd1,
    EVT_ENTER  = 2'd2
  } evt_t;

  // Operations queued from the front to the back.
  typedef enum logic [2:0] {
    OP_WR1     = 3'd0,
    OP_WR2     = 3'd1,
    OP_WR_EMIT = 3'd2,
    OP_EMIT    = 3'd3,
    OP_EVENT   = 3'd4
  } op_t;

  // Back sequencer state.
  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_WR2  = 2'd1,
    B_EMIT = 2'd2
  } back_state_t;

  // One queued command.
  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] addr;
    logic [7:0]       d0;
    logic [7:0]       d1;
    logic [CNT_W-1:0] len;
    evt_t             evt;
  } cmd_t;

  // Mode that a byte opens when it is taken as the first byte of a frame.
  function automatic mode_t start_mode(input logic [7:0] b);
    mode_t m;
    if (b == BYTE_ZIGBEE) begin
      m = MODE_ZIGBEE;
    end else if (b == BYTE_HDR0) begin
      m = MODE_CUSTOM;
    end else if (b == BYTE_B) begin
      m = MODE_WORD;
    end else begin
      m = MODE_IDLE;
    end
    return m;
  endfunction

  // True when a byte stored at a header position breaks the C1 C2 C3 C4 header.
  function automatic logic hdr_miss(input logic [CNT_W-1:0] idx, input logic [7:0] b);
    logic miss;
    miss = ((idx == CNT_W'(1)) && (b != BYTE_HDR1)) ||
           ((idx == CNT_W'(2)) && (b != BYTE_HDR2)) ||
           ((idx == CNT_W'(3)) && (b != BYTE_HDR3));
    return miss;
  endfunction

endpackage

`default_nettype wire

@@ rtl/multi_format_frame_receiver_top.sv @@
// ----------------------------------------------------------------------------
// Multi-format frame receiver
// Hunts received serial bytes for zigbee, custom and word frames and plays
// completed frames out as bursts of bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one received byte per request in in_tdata and the
//   clear flag for the latched enter-mode state in in_tuser. The out_ channel
//   carries one frame byte per request: out_tuser gives the kind (zigbee byte,
//   custom byte or enter-mode event), out_tdata the byte and its position, and
//   out_tlast marks the final byte of a burst.
//   The front takes one byte per cycle as long as the four-entry command queue
//   has room; a byte causes at most one command. The back does store writes,
//   a stored CR with the byte after it as a pair, and bursts of n bytes, one
//   byte per cycle while the receiver takes them, from the single read port of
//   the frame store. A burst's first byte passes the queue, the idle and emit
//   states (just idle for enter mode), the read stage and the output register.
//   Reset returns the block to hunting with no pending output; the frame store
//   is not cleared. When the receiver stalls, the output register holds its
//   request, the back stops, the queue fills and in_tready then falls.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_format_frame_receiver_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // rx_byte
  input  wire logic [0:0]  in_tuser,   // clear_enter_mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // data_byte [7:0], byte_index [13:8], zero fill
  output logic [1:0]       out_tuser,  // event_res
  output logic             out_tlast   // last
);
  import mffr_pkg::*;

  cmd_t push_cmd, head_cmd;
  logic cq_push, cq_full, cq_pop, cq_nempty;

  mffr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cq_full   (cq_full),
    .cq_push   (cq_push),
    .cq_cmd    (push_cmd)
  );

  mffr_cmd_fifo u_cq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cq_push),
    .push_cmd (push_cmd),
    .full     (cq_full),
    .pop      (cq_pop),
    .head_cmd (head_cmd),
    .nempty   (cq_nempty)
  );

  mffr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (head_cmd),
    .cmd_vld    (cq_nempty),
    .cmd_pop    (cq_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

@@ rtl/mffr_front.sv @@
// ----------------------------------------------------------------------------
// Frame receiver front
// Accepts received bytes, tracks the frame mode and issues store and emit
// commands to the back through the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mffr_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [7:0]    in_tdata,   // rx_byte
  input  wire logic [0:0]    in_tuser,   // clear_enter_mode
  input  wire logic          cq_full,
  output logic               cq_push,
  output mffr_pkg::cmd_t     cq_cmd
);
  import mffr_pkg::*;

  mode_t            mode_r, mode_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             cr_r, cr_nxt;
  logic             latched_r, latched_nxt;
  logic             hdr_bad_r, hdr_bad_nxt;
  logic [7:0]       len_r, len_nxt;

  logic             in_acc;
  logic             latched_eff;
  logic [7:0]       b;
  logic [CNT_W-1:0] c1, c2;
  logic [7:0]       len_eff;
  logic [8:0]       len_end;
  logic [8:0]       c1_wide;
  logic             do_start;
  mode_t            st_mode;
  logic             cmd_vld;
  cmd_t             cmd;

  // A request is taken whenever the queue can hold the command it may cause.
  always_comb begin
    in_tready = !cq_full;
    in_acc    = in_tvalid && !cq_full;
  end

  assign b           = in_tdata;
  assign latched_eff = latched_r && !in_tuser[0];
  assign c1          = count_r + CNT_W'(1);
  assign c2          = count_r + CNT_W'(2);
  assign st_mode     = start_mode(b);
  assign len_eff     = (count_r == CNT_W'(1)) ? b : len_r;
  assign len_end     = {1'b0, len_eff} + 9'd2;
  assign c1_wide     = 9'(c1);

  // Next frame state and the command that the byte causes.
  always_comb begin
    mode_nxt    = mode_r;
    count_nxt   = count_r;
    cr_nxt      = cr_r;
    latched_nxt = latched_r;
    hdr_bad_nxt = hdr_bad_r;
    len_nxt     = len_r;
    do_start    = 1'b0;
    cmd_vld     = 1'b0;
    cmd.op      = OP_WR1;
    cmd.addr    = count_r[IDX_W-1:0];
    cmd.d0      = b;
    cmd.d1      = b;
    cmd.len     = count_r;
    cmd.evt     = EVT_ZIGBEE;

    if (in_acc) begin
      latched_nxt = latched_eff;
      unique case (mode_r)
        MODE_ZIGBEE: begin
          len_nxt = len_eff;
          cmd_vld = 1'b1;
          if (c1_wide == len_end) begin
            cmd.op    = OP_WR_EMIT;
            cmd.len   = c1;
            mode_nxt  = MODE_IDLE;
            count_nxt = '0;
            cr_nxt    = 1'b0;
          end else if ((c1_wide > len_end) || (c1 >= BUF_FULL)) begin
            mode_nxt  = MODE_IDLE;
            count_nxt = '0;
            cr_nxt    = 1'b0;
          end else begin
            count_nxt = c1;
          end
        end
        MODE_CUSTOM: begin
          cmd.evt = EVT_CUSTOM;
          if (cr_r) begin
            if (b == BYTE_LF) begin
              // End of a custom frame: emit it only with the full header.
              if ((count_r >= HDR_LEN) && !hdr_bad_r) begin
                cmd_vld = 1'b1;
                cmd.op  = OP_EMIT;
              end
              mode_nxt  = MODE_IDLE;
              count_nxt = '0;
              cr_nxt    = 1'b0;
            end else begin
              // A lone CR is stored, then the byte after it if room is left.
              cr_nxt  = 1'b0;
              cmd_vld = 1'b1;
              cmd.d0  = BYTE_CR;
              if (c1 >= BUF_FULL) begin
                cmd.op    = OP_WR1;
                mode_nxt  = MODE_IDLE;
                count_nxt = '0;
              end else begin
                cmd.op      = OP_WR2;
                hdr_bad_nxt = hdr_bad_r || hdr_miss(count_r, BYTE_CR) || hdr_miss(c1, b);
                if (c2 >= BUF_FULL) begin
                  mode_nxt  = MODE_IDLE;
                  count_nxt = '0;
                end else begin
                  count_nxt = c2;
                end
              end
            end
          end else if (b == BYTE_CR) begin
            cr_nxt = 1'b1;
          end else begin
            cmd_vld     = 1'b1;
            hdr_bad_nxt = hdr_bad_r || hdr_miss(count_r, b);
            if (c1 >= BUF_FULL) begin
              mode_nxt  = MODE_IDLE;
              count_nxt = '0;
            end else begin
              count_nxt = c1;
            end
          end
        end
        MODE_WORD: begin
          if ((b != BYTE_U) && (b != BYTE_S) && (b != BYTE_Y)) begin
            do_start = 1'b1;
          end else if (c1 == WORD_LEN) begin
            count_nxt = c1;
            if (!latched_eff) begin
              latched_nxt = 1'b1;
              cmd_vld     = 1'b1;
              cmd.op      = OP_EVENT;
              cmd.evt     = EVT_ENTER;
            end
          end else if (c1 > WORD_LEN) begin
            do_start = 1'b1;
          end else begin
            count_nxt = c1;
          end
        end
        default: begin
          do_start = 1'b1;
        end
      endcase

      // Take the byte as the first byte of a new frame.
      if (do_start) begin
        mode_nxt    = st_mode;
        cr_nxt      = 1'b0;
        hdr_bad_nxt = 1'b0;
        if (st_mode != MODE_IDLE) begin
          count_nxt = CNT_W'(1);
          cmd_vld   = 1'b1;
          cmd.op    = OP_WR1;
          cmd.addr  = '0;
        end else begin
          count_nxt = '0;
        end
      end
    end
  end

  // Queue write port.
  always_comb begin
    cq_push = in_acc && cmd_vld;
    cq_cmd  = cmd;
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      count_r   <= '0;
      cr_r      <= 1'b0;
      latched_r <= 1'b0;
      hdr_bad_r <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      count_r   <= count_nxt;
      cr_r      <= cr_nxt;
      latched_r <= latched_nxt;
      hdr_bad_r <= hdr_bad_nxt;
    end
  end

  // The length byte of a zigbee frame needs no reset.
  always_ff @(posedge clk) begin
    len_r <= len_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/mffr_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// Frame receiver command queue
// A small first-in first-out queue of commands from the front to the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mffr_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire mffr_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output mffr_pkg::cmd_t      head_cmd,
  output logic                nempty
);
  import mffr_pkg::*;

  cmd_t                entry_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  // Status and head entry.
  always_comb begin
    full     = (cnt_r == CQ_CNT_W'(CQ_DEPTH));
    nempty   = (cnt_r != '0);
    head_cmd = entry_r[rd_ptr_r];
    do_push  = push && !full;
    do_pop   = pop && nempty;
  end

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + CQ_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + CQ_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CQ_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

@@ rtl/mffr_back.sv @@
// ----------------------------------------------------------------------------
// Frame receiver back
// Holds the frame store, carries out queued writes and plays stored frames
// out as bursts through a read stage and an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mffr_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire mffr_pkg::cmd_t cmd,
  input  wire logic           cmd_vld,
  output logic                cmd_pop,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [15:0]         out_tdata,  // data_byte, byte_index, zero fill
  output logic [1:0]          out_tuser,  // event_res
  output logic                out_tlast   // last
);
  import mffr_pkg::*;

  logic [7:0]       mem [BUF_LEN];

  back_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, last_idx_r, wr_addr_r;
  logic [7:0]       wr_data_r;
  evt_t             kind_r;

  // Read stage.
  logic             rd_vld_r;
  logic [7:0]       rdata_r;
  logic             rd_zero_r;
  evt_t             rd_kind_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             rd_last_r;

  // Output register.
  logic             out_vld_r;
  logic [7:0]       out_data_r;
  evt_t             out_kind_r;
  logic [IDX_W-1:0] out_idx_r;
  logic             out_last_r;

  logic             out_load, room;
  logic             we, rd_en, issue, iss_zero, iss_last, iss_emit;
  logic [IDX_W-1:0] waddr, raddr, iss_idx;
  logic [7:0]       wdata;
  evt_t             iss_kind;
  logic             emit_last;

  assign out_load  = rd_vld_r && (!out_vld_r || out_tready);
  assign room      = !rd_vld_r || out_load;
  assign emit_last = (idx_r == last_idx_r);

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (cmd_vld) begin
          unique case (cmd.op)
            OP_WR2:               state_nxt = B_WR2;
            OP_WR_EMIT, OP_EMIT:  state_nxt = B_EMIT;
            default:              state_nxt = B_IDLE;
          endcase
        end
      end
      B_WR2:   state_nxt = B_IDLE;
      B_EMIT: begin
        if (room && emit_last) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Sequencer outputs: store writes, reads and queue pops.
  always_comb begin
    cmd_pop  = 1'b0;
    we       = 1'b0;
    waddr    = cmd.addr;
    wdata    = cmd.d0;
    rd_en    = 1'b0;
    raddr    = idx_r;
    issue    = 1'b0;
    iss_zero = 1'b0;
    iss_kind = kind_r;
    iss_idx  = idx_r;
    iss_last = emit_last;
    iss_emit = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (cmd_vld) begin
          unique case (cmd.op)
            OP_WR1, OP_WR2, OP_WR_EMIT: begin
              cmd_pop  = 1'b1;
              we       = 1'b1;
              iss_emit = (cmd.op == OP_WR_EMIT);
            end
            OP_EMIT: begin
              cmd_pop  = 1'b1;
              iss_emit = 1'b1;
            end
            OP_EVENT: begin
              if (room) begin
                cmd_pop  = 1'b1;
                issue    = 1'b1;
                iss_zero = 1'b1;
                iss_kind = EVT_ENTER;
                iss_idx  = '0;
                iss_last = 1'b1;
              end
            end
            default: cmd_pop = 1'b1;
          endcase
        end
      end
      B_WR2: begin
        we    = 1'b1;
        waddr = wr_addr_r;
        wdata = wr_data_r;
      end
      B_EMIT: begin
        if (room) begin
          rd_en = 1'b1;
          issue = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Burst and second-write bookkeeping.
  always_ff @(posedge clk) begin
    if (iss_emit) begin
      idx_r      <= '0;
      last_idx_r <= IDX_W'(cmd.len - CNT_W'(1));
      kind_r     <= cmd.evt;
    end else if ((state_r == B_EMIT) && issue) begin
      idx_r <= idx_r + IDX_W'(1);
    end
    if (cmd_pop) begin
      wr_addr_r <= cmd.addr + IDX_W'(1);
      wr_data_r <= cmd.d1;
    end
  end

  // Frame store.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  // Read stage and output register valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (issue) begin
        rd_vld_r <= 1'b1;
      end else if (out_load) begin
        rd_vld_r <= 1'b0;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Read stage and output register payload.
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_zero_r <= iss_zero;
      rd_kind_r <= iss_kind;
      rd_idx_r  <= iss_idx;
      rd_last_r <= iss_last;
    end
    if (out_load) begin
      out_data_r <= rd_zero_r ? 8'h00 : rdata_r;
      out_kind_r <= rd_kind_r;
      out_idx_r  <= rd_idx_r;
      out_last_r <= rd_last_r;
    end
  end

  always_comb begin
    out_tvalid = out_vld_r;
    out_tdata  = {2'b00, 6'(out_idx_r), out_data_r};
    out_tuser  = out_kind_r;
    out_tlast  = out_last_r;
  end

endmodule

`default_nettype wire

@@ rtl/mffr_checker.sv @@
// ----------------------------------------------------------------------------
// Frame receiver port checker
// Watches the top-level ports for output handshake and burst ordering slips.
// ----------------------------------------------------------------------------
`default_nettype none

module mffr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  // A stalled result request stays up.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output request dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("output payload changed while stalled");

  // Reset leaves no pending result.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output request after reset");

  // Inside a burst the next result has the same kind and the next position.
  a_burst_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) ##1 out_tvalid |->
      (out_tuser == $past(out_tuser, 1)) &&
      (out_tdata[13:8] == 6'($past(out_tdata[13:8], 1) + 6'd1)))
    else $error("burst bytes out of order");

endmodule

bind multi_format_frame_receiver_top mffr_checker u_mffr_checker (.*);

`default_nettype wire
